[hw/rtl/rpn_pkg.sv]
package rpn_pkg;

    // Default sizes of the operand stack and of the values it holds.
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // Field widths of the token and reply transfers.
    localparam int OP_WIDTH     = 3;
    localparam int NUM_WIDTH    = 32;
    localparam int STATUS_WIDTH = 4;

    // Token operation codes. Code 7 is unused and is handled as an invalid token.
    localparam logic [OP_WIDTH-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_SUB     = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_MUL     = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_DIV     = 3'd4;
    localparam logic [OP_WIDTH-1:0] OP_END     = 3'd5;
    localparam logic [OP_WIDTH-1:0] OP_INVALID = 3'd6;

    // Reply status codes.
    localparam logic [STATUS_WIDTH-1:0] ST_ACCEPTED  = 4'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_RESULT    = 4'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_TOO_FEW   = 4'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_DIV_ZERO  = 4'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_LEFTOVER  = 4'd4;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY     = 4'd5;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 4'd6;
    localparam logic [STATUS_WIDTH-1:0] ST_DISCARDED = 4'd7;
    localparam logic [STATUS_WIDTH-1:0] ST_INVALID   = 4'd8;

    // One input token.
    typedef struct packed {
        logic [OP_WIDTH-1:0]         operation;
        logic signed [NUM_WIDTH-1:0] number;
    } rpn_token_t;

    // One reply.
    typedef struct packed {
        logic [STATUS_WIDTH-1:0]     status;
        logic signed [NUM_WIDTH-1:0] result;
    } rpn_reply_t;

endpackage

[hw/rtl/rpn_stack_evaluator.sv]
// Reverse Polish expression evaluator over signed saturating integers.
// Channels: a token is transferred at a rising edge where start is high and
// busy is low. Every token gives exactly one reply, shown on reply for one
// cycle with done high; the receiver cannot stall, so it must take it then.
// Push, end, invalid, discarded and too-few-operand tokens reply in the
// cycle after the transfer and busy never rises for them. Add and subtract
// do one stack memory read, then use the shared adder; a divide by zero is
// reported after that read. Multiply and divide load the magnitudes, then
// the same adder runs one shift-add or restore-subtract step per cycle, then
// negates and saturates the magnitude. busy is high throughout, and the next
// token may be transferred in the cycle in which done is high.
// Reset clears the stack count, the error latch and the sequencer. Stack
// memory contents are not cleared; only entries below the count are read.
// An end token reports the single remaining value or an error, then empties
// the stack and clears the error latch.
module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  rpn_token_t token,
    output logic       busy,
    output logic       done,
    output rpn_reply_t reply
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SW = $clog2(VALUE_WIDTH);

    localparam logic [W-1:0]        VMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]        VMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [63:0]  VMAX64 = $signed(64'(VMAX));
    localparam logic signed [63:0]  VMIN64 = -VMAX64 - 64'sd1;
    localparam logic [CW-1:0]       DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [SW-1:0]       LAST_STEP = SW'(VALUE_WIDTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_ITER,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    latch_reg, latch_next;
    logic [W-1:0]            top_reg, top_next;
    logic [OP_WIDTH-1:0]     op_reg, op_next;
    logic [W-1:0]            a_reg, a_next;
    logic [W-1:0]            b_reg, b_next;
    logic [W:0]              hi_reg, hi_next;
    logic [W-1:0]            lo_reg, lo_next;
    logic                    neg_reg, neg_next;
    logic [SW-1:0]           step_reg, step_next;
    logic                    done_reg, done_next;
    rpn_reply_t              reply_reg, reply_next;

    // Stack memory with one write and one registered read port.
    logic [W-1:0]            stack_mem [STACK_DEPTH];
    logic [W-1:0]            rd_data_reg;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [W-1:0]            wr_data;
    logic [CW-1:0]           count_m2;
    logic [AW-1:0]           rd_addr;

    // Shared adder used by add, subtract, multiply steps, divide steps and negation.
    logic [W:0]              add_a, add_b, add_sum;
    logic                    add_cin;

    // Operand views and helper values.
    logic signed [63:0]      num_ext;
    logic signed [63:0]      top_ext;
    logic [W-1:0]            push_val;
    logic [W-1:0]            l_val, r_val, l_mag, r_mag;
    logic [W-1:0]            addsub_val;
    logic [W:0]              rem_shift;
    logic                    mul_ovf, div_ovf, fin_ovf;
    logic [W-1:0]            fin_val;

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign reply = reply_reg;

    assign count_m2 = count_reg - CW'(2);
    assign rd_addr  = count_m2[AW-1:0];

    // Pushed numbers saturate to the value range.
    assign num_ext  = 64'($signed(token.number));
    assign push_val = (num_ext > VMAX64) ? VMAX :
                      (num_ext < VMIN64) ? VMIN : num_ext[W-1:0];
    assign top_ext  = 64'($signed(top_reg));

    // Left operand comes from memory, right operand is the cached top entry.
    assign l_val = rd_data_reg;
    assign r_val = top_reg;
    assign l_mag = l_val[W-1] ? ((~l_val) + W'(1)) : l_val;
    assign r_mag = r_val[W-1] ? ((~r_val) + W'(1)) : r_val;

    assign rem_shift = {hi_reg[W-1:0], lo_reg[W-1]};

    // Adder operand selection for each sequencer state.
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                add_a = {l_val[W-1], l_val};
                if (op_reg == OP_SUB)
                begin
                    add_b   = ~{r_val[W-1], r_val};
                    add_cin = 1'b1;
                end
                else
                begin
                    add_b = {r_val[W-1], r_val};
                end
            end
            S_ITER:
            begin
                if (op_reg == OP_MUL)
                begin
                    add_a = hi_reg;
                    add_b = {1'b0, a_reg};
                end
                else
                begin
                    add_a   = rem_shift;
                    add_b   = ~{1'b0, b_reg};
                    add_cin = 1'b1;
                end
            end
            S_FINISH:
            begin
                add_b   = ~{1'b0, lo_reg};
                add_cin = 1'b1;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b + {{W{1'b0}}, add_cin};

    // Add and subtract saturate when the two top sum bits disagree.
    assign addsub_val = (add_sum[W] != add_sum[W-1]) ? (add_sum[W] ? VMIN : VMAX)
                                                     : add_sum[W-1:0];

    // Final magnitude checks for multiply and divide.
    assign mul_ovf = (hi_reg[W-1:0] != '0) ||
                     (lo_reg[W-1] && (!neg_reg || (lo_reg[W-2:0] != '0)));
    assign div_ovf = !neg_reg && lo_reg[W-1];
    assign fin_ovf = (op_reg == OP_MUL) ? mul_ovf : div_ovf;
    assign fin_val = fin_ovf ? (neg_reg ? VMIN : VMAX)
                             : (neg_reg ? add_sum[W-1:0] : lo_reg);

    // Sequencer and token handling.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        latch_next = latch_reg;
        top_next   = top_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        reply_next = reply_reg;
        wr_en      = 1'b0;
        wr_addr    = rd_addr;
        wr_data    = push_val;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    reply_next.result = '0;
                    reply_next.status = ST_ACCEPTED;
                    if (token.operation == OP_END)
                    begin
                        done_next  = 1'b1;
                        count_next = '0;
                        latch_next = 1'b0;
                        if (latch_reg)
                        begin
                            reply_next.status = ST_DISCARDED;
                        end
                        else if (count_reg == '0)
                        begin
                            reply_next.status = ST_EMPTY;
                        end
                        else if (count_reg != CW'(1))
                        begin
                            reply_next.status = ST_LEFTOVER;
                        end
                        else
                        begin
                            reply_next.status = ST_RESULT;
                            reply_next.result = top_ext[NUM_WIDTH-1:0];
                        end
                    end
                    else if (latch_reg)
                    begin
                        done_next         = 1'b1;
                        reply_next.status = ST_DISCARDED;
                    end
                    else if (token.operation == OP_PUSH)
                    begin
                        done_next = 1'b1;
                        if (count_reg == DEPTH_C)
                        begin
                            reply_next.status = ST_FULL;
                            latch_next        = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = push_val;
                            top_next   = push_val;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (token.operation == OP_ADD || token.operation == OP_SUB ||
                             token.operation == OP_MUL || token.operation == OP_DIV)
                    begin
                        if (count_reg < CW'(2))
                        begin
                            done_next         = 1'b1;
                            reply_next.status = ST_TOO_FEW;
                            latch_next        = 1'b1;
                        end
                        else
                        begin
                            op_next    = token.operation;
                            state_next = S_LOAD;
                        end
                    end
                    else
                    begin
                        done_next         = 1'b1;
                        reply_next.status = ST_INVALID;
                        latch_next        = 1'b1;
                    end
                end
            end

            S_LOAD:
            begin
                if (op_reg == OP_DIV && r_val == '0)
                begin
                    done_next         = 1'b1;
                    reply_next.status = ST_DIV_ZERO;
                    latch_next        = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (op_reg == OP_ADD || op_reg == OP_SUB)
                begin
                    wr_en      = 1'b1;
                    wr_data    = addsub_val;
                    top_next   = addsub_val;
                    count_next = count_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    a_next     = l_mag;
                    b_next     = r_mag;
                    hi_next    = '0;
                    lo_next    = (op_reg == OP_MUL) ? r_mag : l_mag;
                    neg_next   = l_val[W-1] ^ r_val[W-1];
                    step_next  = '0;
                    state_next = S_ITER;
                end
            end

            S_ITER:
            begin
                if (op_reg == OP_MUL)
                begin
                    // Shift-add step: add the multiplicand when the low bit is set.
                    if (lo_reg[0])
                    begin
                        hi_next = {1'b0, add_sum[W:1]};
                        lo_next = {add_sum[0], lo_reg[W-1:1]};
                    end
                    else
                    begin
                        hi_next = {1'b0, hi_reg[W:1]};
                        lo_next = {hi_reg[0], lo_reg[W-1:1]};
                    end
                end
                else
                begin
                    // Restoring step: keep the difference when it is not negative.
                    hi_next = add_sum[W] ? rem_shift : add_sum;
                    lo_next = {lo_reg[W-2:0], !add_sum[W]};
                end
                step_next = step_reg + SW'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                wr_en      = 1'b1;
                wr_data    = fin_val;
                top_next   = fin_val;
                count_next = count_reg - CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, control and registered reply.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            latch_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            latch_reg <= latch_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        neg_reg   <= neg_next;
        step_reg  <= step_next;
        reply_reg <= reply_next;
    end

    // Stack memory.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

endmodule

[verif/rpn_stack_evaluator_test.sv]
module rpn_stack_evaluator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    localparam int STACK_DEPTH = DEF_STACK_DEPTH;
    localparam int RANDOM_TARGET = 1100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    // The unused code, which the block handles as an invalid token.
    localparam logic [OP_WIDTH-1:0] OP_UNUSED = 3'd7;

    localparam logic signed [NUM_WIDTH-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [NUM_WIDTH-1:0] VAL_MIN = 32'sh80000000;

    typedef struct {
        rpn_token_t tok;
        int         idle_pct;
        bit         drain_first;
    } backlog_entry_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    rpn_token_t token = '0;
    logic       busy;
    logic       done;
    rpn_reply_t reply;

    backlog_entry_t token_backlog[$];
    rpn_reply_t     expected_replies[$];

    // Shadow copy of the operand stack and the error latch.
    logic signed [NUM_WIDTH-1:0] shadow_stack [STACK_DEPTH];
    int  shadow_depth = 0;
    bit  shadow_latched = 1'b0;

    logic token_taken = 1'b0;
    int   stall_cycles = 0;
    int   error_count = 0;

    // Generator settings for the tokens being queued.
    int cur_idle_pct = 0;
    bit cur_drain = 1'b0;

    rpn_stack_evaluator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .token (token),
        .busy  (busy),
        .done  (done),
        .reply (reply)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Saturate a wide intermediate value to the signed value range.
    function automatic logic signed [NUM_WIDTH-1:0] clamp_value(longint v);
        if (v > longint'(VAL_MAX))
            return VAL_MAX;
        if (v < longint'(VAL_MIN))
            return VAL_MIN;
        return v[NUM_WIDTH-1:0];
    endfunction

    // Apply one token to the shadow stack and return the reply it causes.
    function automatic rpn_reply_t evaluate_token(rpn_token_t tok);
        rpn_reply_t rep;
        longint lhs;
        longint rhs;
        longint acc;
        rep.status = ST_ACCEPTED;
        rep.result = '0;
        if (tok.operation == OP_END)
        begin
            if (shadow_latched)
                rep.status = ST_DISCARDED;
            else if (shadow_depth == 0)
                rep.status = ST_EMPTY;
            else if (shadow_depth > 1)
                rep.status = ST_LEFTOVER;
            else
            begin
                rep.status = ST_RESULT;
                rep.result = shadow_stack[0];
            end
            shadow_depth = 0;
            shadow_latched = 1'b0;
        end
        else if (shadow_latched)
        begin
            rep.status = ST_DISCARDED;
        end
        else if (tok.operation == OP_PUSH)
        begin
            if (shadow_depth >= STACK_DEPTH)
            begin
                rep.status = ST_FULL;
                shadow_latched = 1'b1;
            end
            else
            begin
                shadow_stack[shadow_depth] = tok.number;
                shadow_depth++;
            end
        end
        else if (tok.operation >= OP_ADD && tok.operation <= OP_DIV)
        begin
            if (shadow_depth < 2)
            begin
                rep.status = ST_TOO_FEW;
                shadow_latched = 1'b1;
            end
            else
            begin
                rhs = shadow_stack[shadow_depth - 1];
                lhs = shadow_stack[shadow_depth - 2];
                if (tok.operation == OP_DIV && rhs == 0)
                begin
                    rep.status = ST_DIV_ZERO;
                    shadow_latched = 1'b1;
                end
                else
                begin
                    // Both operands fit in 32 bits, so 64-bit math never wraps.
                    if (tok.operation == OP_ADD)
                        acc = lhs + rhs;
                    else if (tok.operation == OP_SUB)
                        acc = lhs - rhs;
                    else if (tok.operation == OP_MUL)
                        acc = lhs * rhs;
                    else
                        acc = lhs / rhs;
                    shadow_depth--;
                    shadow_stack[shadow_depth - 1] = clamp_value(acc);
                end
            end
        end
        else
        begin
            rep.status = ST_INVALID;
            shadow_latched = 1'b1;
        end
        return rep;
    endfunction

    function automatic logic signed [NUM_WIDTH-1:0] pick_number();
        int small_val;
        small_val = $urandom_range(0, 200);
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return -1;
            4, 5: return small_val - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_WIDTH-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return OP_ADD;
            1: return OP_SUB;
            2: return OP_MUL;
            default: return OP_DIV;
        endcase
    endfunction

    task automatic queue_token(logic [OP_WIDTH-1:0] op, logic signed [NUM_WIDTH-1:0] num);
        backlog_entry_t entry;
        entry.tok.operation = op;
        entry.tok.number = num;
        entry.idle_pct = cur_idle_pct;
        entry.drain_first = cur_drain;
        cur_drain = 1'b0;
        token_backlog.push_back(entry);
    endtask

    // Queue a well-formed postfix expression with the given number of leaves.
    task automatic queue_expression(int leaves, bit push_first);
        int to_push;
        int depth;
        to_push = leaves;
        depth = 0;
        while (to_push > 0 || depth > 1)
        begin
            if (depth >= 2 && (to_push == 0 || (!push_first && $urandom_range(0, 1) == 1)))
            begin
                queue_token(pick_operator(), $urandom);
                depth--;
            end
            else
            begin
                queue_token(OP_PUSH, pick_number());
                depth++;
                to_push--;
            end
        end
    endtask

    // Stimulus: directed cases, then random sequences in idling phases.
    initial
    begin
        int idle_by_phase[3];
        int phase;
        int last_phase;
        idle_by_phase = '{0, 53, 16};
        last_phase = 0;

        // Saturating multiply and subtract.
        queue_token(OP_PUSH, VAL_MAX);
        queue_token(OP_PUSH, VAL_MAX);
        queue_token(OP_MUL, $urandom);
        queue_token(OP_PUSH, VAL_MIN);
        queue_token(OP_SUB, $urandom);
        queue_token(OP_END, $urandom);
        // Minimum divided by minus one saturates.
        queue_token(OP_PUSH, VAL_MIN);
        queue_token(OP_PUSH, -1);
        queue_token(OP_DIV, $urandom);
        queue_token(OP_END, $urandom);
        // Division truncates toward zero; the add saturates low.
        queue_token(OP_PUSH, -7);
        queue_token(OP_PUSH, 2);
        queue_token(OP_DIV, $urandom);
        queue_token(OP_PUSH, VAL_MIN);
        queue_token(OP_ADD, $urandom);
        queue_token(OP_END, $urandom);
        // Division by zero latches; later tokens are discarded.
        queue_token(OP_PUSH, 5);
        queue_token(OP_PUSH, 0);
        queue_token(OP_DIV, $urandom);
        queue_token(OP_PUSH, 1);
        queue_token(OP_END, $urandom);
        // Unused code is invalid, then an invalid token is discarded.
        queue_token(OP_UNUSED, $urandom);
        queue_token(OP_INVALID, $urandom);
        queue_token(OP_END, $urandom);
        // Too few operands, then end on an empty stack.
        queue_token(OP_ADD, $urandom);
        queue_token(OP_END, $urandom);
        queue_token(OP_END, $urandom);

        while (token_backlog.size() < RANDOM_TARGET)
        begin
            phase = token_backlog.size() * 3 / RANDOM_TARGET;
            cur_idle_pct = idle_by_phase[phase];
            if (phase != last_phase || $urandom_range(0, 49) == 0)
                cur_drain = 1'b1;
            last_phase = phase;
            case ($urandom_range(0, 9))
                0:
                begin
                    // Noise: arbitrary codes, then an end marker.
                    repeat ($urandom_range(1, 6))
                        queue_token(OP_WIDTH'($urandom_range(0, 2**OP_WIDTH - 1)),
                                    pick_number());
                    queue_token(OP_END, $urandom);
                end
                1:
                begin
                    // A complete expression followed by one stray token.
                    queue_expression($urandom_range(1, 6), 1'b0);
                    if ($urandom_range(0, 1) == 1)
                        queue_token(pick_operator(), $urandom);
                    else
                        queue_token(OP_PUSH, pick_number());
                    queue_token(OP_END, $urandom);
                end
                2:
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        // Fill the stack to the top, then reduce it.
                        queue_expression(STACK_DEPTH, 1'b1);
                    end
                    else
                    begin
                        // Overfill the stack.
                        repeat (STACK_DEPTH + $urandom_range(1, 2))
                            queue_token(OP_PUSH, pick_number());
                        queue_token(pick_operator(), $urandom);
                    end
                    queue_token(OP_END, $urandom);
                end
                default:
                begin
                    queue_expression($urandom_range(1, 8), $urandom_range(0, 3) == 0);
                    queue_token(OP_END, $urandom);
                end
            endcase
        end

        // Reset is released on a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (token_backlog.size() != 0 || start)
            @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_replies.size() != 0)
        begin
            error_count++;
            $display("%0d replies never arrived", expected_replies.size());
        end
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Driver: present the next token on the falling edge once the last one
    // has been transferred, idling at random as the token's phase asks.
    always @(negedge clk)
    begin : drive_tokens
        backlog_entry_t nxt;
        bit present;
        present = 1'b0;
        if (rst_n && (!start || token_taken))
        begin
            if (token_backlog.size() != 0)
            begin
                nxt = token_backlog[0];
                if (nxt.drain_first && expected_replies.size() != 0)
                    present = 1'b0;
                else if ($urandom_range(0, 99) < nxt.idle_pct)
                    present = 1'b0;
                else
                    present = 1'b1;
            end
            if (present)
            begin
                void'(token_backlog.pop_front());
                start <= 1'b1;
                token <= nxt.tok;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check each reply against the oldest expectation, then record
    // the expectation of any token transferred at this edge.
    always @(posedge clk)
    begin : watch_replies
        rpn_reply_t want;
        if (rst_n)
        begin
            token_taken <= start && !busy;
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Unexpected reply: status %0d result %0d",
                                 reply.status, reply.result);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (reply.status !== want.status || reply.result !== want.result)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("Mismatch: expected status %0d result %0d,",
                                     want.status, want.result,
                                     " got status %0d result %0d",
                                     reply.status, reply.result);
                    end
                end
            end
            if (start && !busy)
                expected_replies.push_back(evaluate_token(token));

            // Watchdog on cycles without any transfer.
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", stall_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
